// ----- rtl/core/skaa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skaa_pkg: shared types and constants for the site keyed arena allocator
// Request and result payloads, status codes, sequencer states and the
// control bundle that the sequencer drives into the datapath.
// ----------------------------------------------------------------------------
package skaa_pkg;

	// fixed field widths
	localparam int unsigned SITE_W = 63;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned ADDR_W = 14;

	typedef enum logic {
		OP_ADDR = 1'b0,
		OP_SEAL = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_FAILED       = 3'd1,
		ST_INVALID      = 3'd2,
		ST_INCONSISTENT = 3'd3,
		ST_SEALED       = 3'd4,
		ST_ALIGN        = 3'd5,
		ST_BUDGET       = 3'd6,
		ST_FULL         = 3'd7
	} status_t;

	typedef struct packed {
		op_t                operation;
		logic [SITE_W-1:0]  site;
		logic [WORD_W-1:0]  size;
		logic [WORD_W-1:0]  alignment;
		logic [WORD_W-1:0]  offset;
	} request_t;

	typedef struct packed {
		logic               address_ok;
		logic [ADDR_W-1:0]  byte_address;
		status_t            status;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_LOOK,
		S_NEWSITE,
		S_ALLOC
	} state_t;

	// per-cycle controls from the sequencer
	typedef struct packed {
		logic    finish;
		logic    set_failed;
		logic    set_sealed;
		logic    wr_en;
		logic    idx_inc;
		logic    load_aligned;
		result_t res;
	} ctl_t;

endpackage

// ----- rtl/core/skaa_site_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skaa_site_table: site table memory
// One write port and one read port; read data is registered. Contents are
// not reset; only entries below the fill count are ever used.
// ----------------------------------------------------------------------------
module skaa_site_table #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned KEY_W = 63,
	parameter int unsigned AW    = 15
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [KEY_W-1:0]         wr_site,
	input  logic [AW-1:0]            wr_base,
	input  logic [AW-1:0]            wr_size,
	input  logic [AW-1:0]            wr_align,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [KEY_W-1:0]         rd_site,
	output logic [AW-1:0]            rd_base,
	output logic [AW-1:0]            rd_size,
	output logic [AW-1:0]            rd_align
);

	logic [KEY_W-1:0] site_mem  [DEPTH];
	logic [AW-1:0]    base_mem  [DEPTH];
	logic [AW-1:0]    size_mem  [DEPTH];
	logic [AW-1:0]    align_mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			site_mem[wr_addr]  <= wr_site;
			base_mem[wr_addr]  <= wr_base;
			size_mem[wr_addr]  <= wr_size;
			align_mem[wr_addr] <= wr_align;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_site  <= site_mem[rd_addr];
		rd_base  <= base_mem[rd_addr];
		rd_size  <= size_mem[rd_addr];
		rd_align <= align_mem[rd_addr];
	end

endmodule

// ----- rtl/core/site_keyed_arena_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// site_keyed_arena_allocator_core: site keyed bump allocator, top level
// Validates a request, walks the site table with one shared key comparator,
// and on a miss bump-allocates an aligned base from the arena.
// ----------------------------------------------------------------------------
// Sequence: the check state answers a seal, an already failed or an invalid request;
// otherwise the table is walked entry by entry and a hit answers; a miss or an empty
// table leads to the new-site state, which refuses for a sealed table or alignment
// overflow and else goes on to the allocate state. One request at a time: the next
// is accepted at the edge that ends the done cycle; results cannot be stalled.
// Reset clears fill count, free pointer and seal/fail flags; table is not cleared.
module site_keyed_arena_allocator_core #(
	parameter int unsigned ARENA_BYTES   = 16384,
	parameter int unsigned TABLE_ENTRIES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  skaa_pkg::request_t request,
	output logic               busy,
	output logic               done,
	output skaa_pkg::result_t  result
);

	localparam int unsigned AW = $clog2(ARENA_BYTES + 1);
	localparam int unsigned IW = $clog2(TABLE_ENTRIES);
	localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [AW:0]   ARENA_X  = (AW+1)'(ARENA_BYTES);
	localparam logic [CW-1:0] ENTRIES_C = CW'(TABLE_ENTRIES);

	skaa_pkg::state_t   state_q, state_d;
	skaa_pkg::request_t req_q;
	skaa_pkg::ctl_t     ctl;

	logic [CW-1:0] idx_q, idx_nx;
	logic [CW-1:0] count_q;
	logic [AW-1:0] next_free_q;
	logic [AW-1:0] aligned_q;
	logic          sealed_q, failed_q;

	logic [IW-1:0]                rd_addr;
	logic [skaa_pkg::SITE_W-1:0]  rd_site;
	logic [AW-1:0]                rd_base, rd_size, rd_align;

	logic          is_seal, invalid_c, hit_c, consist_c, last_c;
	logic          align_ovf_c, budget_c, full_c;
	logic [AW-1:0] align_n;
	logic [AW:0]   align_m1, bumped, aligned_c;

	assign busy   = (state_q != skaa_pkg::S_IDLE);
	assign idx_nx = idx_q + CW'(1);

	// request screening
	assign is_seal   = (req_q.operation == skaa_pkg::OP_SEAL);
	assign invalid_c = (req_q.size == '0) || (req_q.alignment == '0) ||
		(req_q.alignment > skaa_pkg::WORD_W'(ARENA_BYTES)) ||
		((req_q.alignment & (req_q.alignment - 32'd1)) != '0) ||
		(req_q.offset >= req_q.size);

	// shared key compare against the entry just read
	assign hit_c     = (rd_site == req_q.site);
	assign consist_c = (req_q.size == skaa_pkg::WORD_W'(rd_size)) &&
		(req_q.alignment == skaa_pkg::WORD_W'(rd_align));
	assign last_c    = (idx_nx == count_q);

	// bump arithmetic; alignment is known to be at most the arena size here
	assign align_n     = req_q.alignment[AW-1:0];
	assign align_m1    = {1'b0, align_n} - (AW+1)'(1);
	assign align_ovf_c = ({1'b0, next_free_q} > (ARENA_X - align_m1));
	assign bumped      = {1'b0, next_free_q} + align_m1;
	assign aligned_c   = bumped & ~align_m1;
	assign budget_c    = (req_q.size > skaa_pkg::WORD_W'(ARENA_X - {1'b0, aligned_q}));
	assign full_c      = (count_q >= ENTRIES_C);

	assign rd_addr = (state_q == skaa_pkg::S_LOOK) ? idx_nx[IW-1:0] : '0;

	skaa_site_table #(
		.DEPTH (TABLE_ENTRIES),
		.KEY_W (skaa_pkg::SITE_W),
		.AW    (AW)
	) u_table (
		.clk      (clk),
		.wr_en    (ctl.wr_en),
		.wr_addr  (count_q[IW-1:0]),
		.wr_site  (req_q.site),
		.wr_base  (aligned_q),
		.wr_size  (req_q.size[AW-1:0]),
		.wr_align (align_n),
		.rd_addr  (rd_addr),
		.rd_site  (rd_site),
		.rd_base  (rd_base),
		.rd_size  (rd_size),
		.rd_align (rd_align)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			skaa_pkg::S_IDLE: begin
				if (start) state_d = skaa_pkg::S_CHECK;
			end
			skaa_pkg::S_CHECK: begin
				if (is_seal || failed_q || invalid_c) state_d = skaa_pkg::S_IDLE;
				else if (count_q == '0)               state_d = skaa_pkg::S_NEWSITE;
				else                                  state_d = skaa_pkg::S_LOOK;
			end
			skaa_pkg::S_LOOK: begin
				if (hit_c)       state_d = skaa_pkg::S_IDLE;
				else if (last_c) state_d = skaa_pkg::S_NEWSITE;
			end
			skaa_pkg::S_NEWSITE: begin
				if (sealed_q || align_ovf_c) state_d = skaa_pkg::S_IDLE;
				else                         state_d = skaa_pkg::S_ALLOC;
			end
			skaa_pkg::S_ALLOC: state_d = skaa_pkg::S_IDLE;
			default:           state_d = skaa_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctl = '0;
		ctl.res.status = skaa_pkg::ST_OK;
		case (state_q)
			skaa_pkg::S_CHECK: begin
				if (is_seal) begin
					ctl.finish     = 1'b1;
					ctl.set_sealed = 1'b1;
				end else if (failed_q) begin
					ctl.finish     = 1'b1;
					ctl.res.status = skaa_pkg::ST_FAILED;
				end else if (invalid_c) begin
					ctl.finish     = 1'b1;
					ctl.set_failed = 1'b1;
					ctl.res.status = skaa_pkg::ST_INVALID;
				end
			end
			skaa_pkg::S_LOOK: begin
				if (hit_c) begin
					ctl.finish = 1'b1;
					if (!consist_c) begin
						ctl.set_failed = 1'b1;
						ctl.res.status = skaa_pkg::ST_INCONSISTENT;
					end else begin
						ctl.res.address_ok   = 1'b1;
						ctl.res.byte_address = skaa_pkg::ADDR_W'(rd_base) +
							req_q.offset[skaa_pkg::ADDR_W-1:0];
					end
				end else begin
					ctl.idx_inc = 1'b1;
				end
			end
			skaa_pkg::S_NEWSITE: begin
				if (sealed_q) begin
					ctl.finish     = 1'b1;
					ctl.set_failed = 1'b1;
					ctl.res.status = skaa_pkg::ST_SEALED;
				end else if (align_ovf_c) begin
					ctl.finish     = 1'b1;
					ctl.set_failed = 1'b1;
					ctl.res.status = skaa_pkg::ST_ALIGN;
				end else begin
					ctl.load_aligned = 1'b1;
				end
			end
			skaa_pkg::S_ALLOC: begin
				ctl.finish = 1'b1;
				if (budget_c) begin
					ctl.set_failed = 1'b1;
					ctl.res.status = skaa_pkg::ST_BUDGET;
				end else if (full_c) begin
					ctl.set_failed = 1'b1;
					ctl.res.status = skaa_pkg::ST_FULL;
				end else begin
					ctl.wr_en            = 1'b1;
					ctl.res.address_ok   = 1'b1;
					ctl.res.byte_address = skaa_pkg::ADDR_W'(aligned_q) +
						req_q.offset[skaa_pkg::ADDR_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skaa_pkg::S_IDLE;
			idx_q       <= '0;
			count_q     <= '0;
			next_free_q <= '0;
			sealed_q    <= 1'b0;
			failed_q    <= 1'b0;
			done        <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= ctl.finish;
			if (start && !busy) idx_q <= '0;
			else if (ctl.idx_inc) idx_q <= idx_nx;
			if (ctl.set_sealed) sealed_q <= 1'b1;
			if (ctl.set_failed) failed_q <= 1'b1;
			if (ctl.wr_en) begin
				count_q     <= count_q + CW'(1);
				next_free_q <= aligned_q + req_q.size[AW-1:0];
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (start && !busy) req_q <= request;
		if (ctl.load_aligned) aligned_q <= aligned_c[AW-1:0];
		if (ctl.finish) result <= ctl.res;
	end

	// checks
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");

	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.address_ok) |-> (result.status == skaa_pkg::ST_OK))
		else $error("valid address with error status");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ENTRIES_C) else $error("site table overfilled");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, next_free_q} <= ARENA_X) else $error("free pointer past arena");

	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(failed_q)) else $error("failure flag cleared");

endmodule

// ----- sim/tb_site_keyed_arena_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_site_keyed_arena_allocator_core: self-checking bench for the allocator
// Drives address and seal requests through the start/busy handshake and
// checks every done strobe against an in-bench allocation predictor (for
// typed rows, a planned result). The first error fails the allocator for
// good, and reset is applied only once. For that reason the run builds and
// walks a healthy site table first, then late in the run sends bad requests
// of random kinds until one sticks; later address requests must be refused.
// ----------------------------------------------------------------------------
module tb_site_keyed_arena_allocator_core;

	localparam int unsigned ARENA_SIZE   = 16384;
	localparam int unsigned SITE_SLOTS   = 16;
	localparam int unsigned RANDOM_ITEMS = 1890;
	localparam int unsigned PHASE_ITEMS  = 630;
	localparam int unsigned DRAIN_CYCLES = 3 + SITE_SLOTS + 8;
	localparam int unsigned PROBE_DEPTH  = 16;
	localparam int unsigned GRANT_DEPTH  = 8;
	// worst case fresh site needs this much arena, so random growth never overflows
	localparam int unsigned GROW_ROOM    = 64 + 256;

	logic               clk;
	logic               arst_n;
	logic               start;
	skaa_pkg::request_t request;
	logic               busy;
	logic               done;
	skaa_pkg::result_t  result;

	typedef struct {
		skaa_pkg::request_t req;
		bit                 typed;
		skaa_pkg::result_t  want;
	} probe_row_t;

	probe_row_t        probe_rows[PROBE_DEPTH];
	int unsigned       probe_count;
	// expected results in request order
	skaa_pkg::result_t grant_fifo[GRANT_DEPTH];
	int unsigned       grant_wr;
	int unsigned       grant_rd;
	int                mismatch_count;
	int                idle_pct;

	// predictor copy of the site table and arena state
	logic [skaa_pkg::SITE_W-1:0] site_key[SITE_SLOTS];
	int unsigned                 site_base[SITE_SLOTS];
	int unsigned                 site_size[SITE_SLOTS];
	int unsigned                 site_align[SITE_SLOTS];
	int unsigned                 site_count;
	int unsigned                 free_ptr;
	bit                          arena_sealed;
	bit                          arena_failed;

	site_keyed_arena_allocator_core #(
		.ARENA_BYTES  (ARENA_SIZE),
		.TABLE_ENTRIES(SITE_SLOTS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.request(request),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(string what);
		mismatch_count++;
		$display("[%0t] allocator mismatch: %s", $time, what);
	endtask

	// any refusal except the already-failed one poisons the allocator
	function automatic skaa_pkg::result_t refusal(skaa_pkg::status_t why);
		skaa_pkg::result_t res;
		arena_failed = 1'b1;
		res.address_ok = 1'b0;
		res.byte_address = '0;
		res.status = why;
		return res;
	endfunction

	function automatic skaa_pkg::result_t predict_allocation(skaa_pkg::request_t r);
		skaa_pkg::result_t res;
		int unsigned       aligned;
		logic [31:0]       sum;
		res.address_ok = 1'b0;
		res.byte_address = '0;
		res.status = skaa_pkg::ST_OK;
		if (r.operation == skaa_pkg::OP_SEAL) begin
			arena_sealed = 1'b1;
			return res;
		end
		if (arena_failed) begin
			res.status = skaa_pkg::ST_FAILED;
			return res;
		end
		// malformed request is caught before the table is looked at
		if (r.size == 0 || r.alignment == 0 || r.alignment > ARENA_SIZE ||
				(r.alignment & (r.alignment - 1)) != 0 || r.offset >= r.size)
			return refusal(skaa_pkg::ST_INVALID);
		for (int i = 0; i < site_count; i++) begin
			if (site_key[i] == r.site) begin
				if (site_size[i] != r.size || site_align[i] != r.alignment)
					return refusal(skaa_pkg::ST_INCONSISTENT);
				sum = site_base[i] + r.offset;
				res.address_ok = 1'b1;
				res.byte_address = sum[skaa_pkg::ADDR_W-1:0];
				return res;
			end
		end
		// unknown site: bump allocate, in this order of checks
		if (arena_sealed)
			return refusal(skaa_pkg::ST_SEALED);
		if (free_ptr > ARENA_SIZE - (r.alignment - 1))
			return refusal(skaa_pkg::ST_ALIGN);
		aligned = (free_ptr + r.alignment - 1) & ~(r.alignment - 1);
		if (r.size > ARENA_SIZE - aligned)
			return refusal(skaa_pkg::ST_BUDGET);
		if (site_count >= SITE_SLOTS)
			return refusal(skaa_pkg::ST_FULL);
		site_key[site_count] = r.site;
		site_base[site_count] = aligned;
		site_size[site_count] = r.size;
		site_align[site_count] = r.alignment;
		site_count++;
		free_ptr = aligned + r.size;
		sum = aligned + r.offset;
		res.address_ok = 1'b1;
		res.byte_address = sum[skaa_pkg::ADDR_W-1:0];
		return res;
	endfunction

	function automatic skaa_pkg::request_t scrambled_request();
		skaa_pkg::request_t r;
		logic [63:0]        key;
		key = {$urandom, $urandom};
		r.operation = skaa_pkg::op_t'($urandom_range(1));
		r.site = key[skaa_pkg::SITE_W-1:0];
		r.size = $urandom;
		r.alignment = $urandom;
		r.offset = $urandom;
		return r;
	endfunction

	function automatic void plan_row(skaa_pkg::op_t op, logic [skaa_pkg::SITE_W-1:0] key,
			logic [skaa_pkg::WORD_W-1:0] bytes, logic [skaa_pkg::WORD_W-1:0] align,
			logic [skaa_pkg::WORD_W-1:0] offs, bit typed = 1'b0,
			logic [skaa_pkg::ADDR_W-1:0] addr = '0);
		probe_row_t row;
		row.req.operation = op;
		row.req.site = key;
		row.req.size = bytes;
		row.req.alignment = align;
		row.req.offset = offs;
		row.typed = typed;
		row.want.address_ok = typed;
		row.want.byte_address = addr;
		row.want.status = skaa_pkg::ST_OK;
		probe_rows[probe_count] = row;
		probe_count++;
	endfunction

	// present one request, hold it until taken, then log what it should return
	task automatic send_request(skaa_pkg::request_t r, bit typed, skaa_pkg::result_t want);
		skaa_pkg::result_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			request <= scrambled_request();
			@(posedge clk);
		end
		request <= r;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = predict_allocation(r);
		grant_fifo[grant_wr % GRANT_DEPTH] = typed ? want : predicted;
		grant_wr++;
	endtask

	// result checker: one expectation per done strobe, in order
	always @(posedge clk) begin : check_results
		skaa_pkg::result_t want;
		if (arst_n && done) begin
			if (grant_wr == grant_rd) begin
				report_mismatch($sformatf("unexpected result ok=%0b addr=%0d status=%0d",
					result.address_ok, result.byte_address, result.status));
			end else begin
				want = grant_fifo[grant_rd % GRANT_DEPTH];
				grant_rd++;
				if (result.address_ok !== want.address_ok)
					report_mismatch($sformatf("address_ok %0b, want %0b",
						result.address_ok, want.address_ok));
				if (result.byte_address !== want.byte_address)
					report_mismatch($sformatf("byte_address %0d, want %0d",
						result.byte_address, want.byte_address));
				if (result.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d",
						result.status, want.status));
			end
		end
	end

	initial begin
		#5_000_000;
		$display("tb_site_keyed_arena_allocator_core: errors");
		$finish;
	end

	initial begin
		skaa_pkg::request_t r;
		skaa_pkg::result_t  none;
		int unsigned        n;
		int unsigned        pick;
		int unsigned        slot;
		int unsigned        break_at;
		arst_n <= 1'b0;
		start <= 1'b0;
		request <= '0;
		none = '0;
		probe_count = 0;
		grant_wr = 0;
		grant_rd = 0;
		mismatch_count = 0;
		idle_pct = 14;
		site_count = 0;
		free_ptr = 0;
		arena_sealed = 1'b0;
		arena_failed = 1'b0;

		// healthy opening: widest alignment, extreme keys, table walk depths
		plan_row(skaa_pkg::OP_ADDR, '0, 32'd1, ARENA_SIZE, 32'd0, 1'b1, 14'd0);
		plan_row(skaa_pkg::OP_ADDR, {skaa_pkg::SITE_W{1'b1}}, 32'd16, 32'd16, 32'd15,
			1'b1, 14'd31);
		plan_row(skaa_pkg::OP_ADDR, '0, 32'd1, ARENA_SIZE, 32'd0, 1'b1, 14'd0);
		plan_row(skaa_pkg::OP_ADDR, {skaa_pkg::SITE_W{1'b1}}, 32'd16, 32'd16, 32'd0,
			1'b1, 14'd16);
		plan_row(skaa_pkg::OP_ADDR, 63'h5555_5555_5555_5555, 32'd100, 32'd1, 32'd99);
		plan_row(skaa_pkg::OP_ADDR, 63'h2AAA_AAAA_AAAA_AAAA, 32'd1, 32'd4096, 32'd0);
		plan_row(skaa_pkg::OP_ADDR, 63'h1, 32'd2048, 32'd2048, 32'd2047);
		plan_row(skaa_pkg::OP_ADDR, 63'h4000_0000_0000_0000, 32'd3, 32'd2, 32'd1);
		plan_row(skaa_pkg::OP_ADDR, 63'h5555_5555_5555_5555, 32'd100, 32'd1, 32'd0);
		plan_row(skaa_pkg::OP_ADDR, 63'h2AAA_AAAA_AAAA_AAAA, 32'd1, 32'd4096, 32'd0);
		plan_row(skaa_pkg::OP_ADDR, 63'h1, 32'd2048, 32'd2048, 32'd1024);
		plan_row(skaa_pkg::OP_ADDR, {skaa_pkg::SITE_W{1'b1}}, 32'd16, 32'd16, 32'd7);
		plan_row(skaa_pkg::OP_ADDR, 63'h4000_0000_0000_0000, 32'd3, 32'd2, 32'd2);
		plan_row(skaa_pkg::OP_ADDR, '0, 32'd1, ARENA_SIZE, 32'd0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < probe_count; i++)
			send_request(probe_rows[i].req, probe_rows[i].typed, probe_rows[i].want);

		// seals and new sites arrive at random; bad requests land late until one sticks
		break_at = $urandom_range(1750, 1300);
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == PHASE_ITEMS)
				idle_pct = 69;
			else if (n == 2 * PHASE_ITEMS)
				idle_pct = 0;
			r = scrambled_request();
			r.operation = skaa_pkg::OP_ADDR;
			pick = $urandom_range(99);
			slot = $urandom_range(site_count - 1);
			if (arena_failed) begin
				// dead allocator: raw traffic, a seal now and then
				if (pick < 12)
					r.operation = skaa_pkg::OP_SEAL;
			end else if (n < break_at) begin
				if ($urandom_range(399) == 0) begin
					r.operation = skaa_pkg::OP_SEAL;
				end else if (pick < 30 && !arena_sealed && site_count < SITE_SLOTS &&
						free_ptr + GROW_ROOM <= ARENA_SIZE) begin
					// fresh site that is sure to fit
					r.alignment = 32'd1 << $urandom_range(6);
					r.size = $urandom_range(256, 1);
					r.offset = $urandom_range(r.size - 1);
				end else begin
					// hit on a known site
					r.site = site_key[slot];
					r.size = site_size[slot];
					r.alignment = site_align[slot];
					case ($urandom_range(3))
						0: r.offset = '0;
						1: r.offset = r.size - 1;
						default: r.offset = $urandom_range(r.size - 1);
					endcase
				end
			end else begin
				// try to break the allocator; retried until it sticks
				r.size = $urandom_range(256, 1);
				r.alignment = 32'd1;
				r.offset = '0;
				case ($urandom_range(5))
					0: begin
						if (pick < 50)
							r.site = site_key[slot];
						case ($urandom_range(4))
							0: r.size = '0;
							1: r.alignment = '0;
							2: r.alignment = $urandom | 32'h3;
							3: r.alignment = 32'd1 << $urandom_range(31, 15);
							default: r.offset = $urandom_range(32'hFFFF_FFFF, r.size);
						endcase
					end
					1: begin
						// known site asked with a different shape
						r.site = site_key[slot];
						r.size = site_size[slot];
						r.alignment = site_align[slot];
						if (pick < 50)
							r.size = site_size[slot] + 1;
						else
							r.alignment = (site_align[slot] == 1) ? 32'd2 : site_align[slot] >> 1;
					end
					2: r.alignment = ARENA_SIZE;
					3: begin
						r.size = ARENA_SIZE - free_ptr + 1 + ($urandom & 32'h7FFF_FFFF);
						r.offset = $urandom_range(r.size - 1);
					end
					default: ;
				endcase
			end
			send_request(r, 1'b0, none);
		end
		start <= 1'b0;

		while (grant_wr != grant_rd)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_site_keyed_arena_allocator_core: clean");
		else
			$display("tb_site_keyed_arena_allocator_core: errors");
		$finish;
	end

endmodule
